// ----- rtl/wsdb_pkg.sv -----
// Shared constants and types for the work-stealing deque bank.
package wsdb_pkg;

  // Bank geometry
  localparam int NUM_DEQUES  = 8;
  localparam int DEQUE_DEPTH = 256;

  // Field widths
  localparam int OP_W     = 2;
  localparam int DQ_FLD_W = 3;
  localparam int JOB_W    = 32;
  localparam int ST_W     = 2;
  localparam int S_DATA_W = ((DQ_FLD_W + JOB_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((JOB_W + 7) / 8) * 8;

  // Derived widths
  localparam int DQ_W   = (NUM_DEQUES > 1) ? $clog2(NUM_DEQUES) : 1;
  localparam int SLOT_W = $clog2(DEQUE_DEPTH);
  localparam int CNT_W  = $clog2(DEQUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_DEQUES * DEQUE_DEPTH;
  localparam int ADDR_W = $clog2(RAM_DEPTH);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_PUBLISH = 2'd1;
  localparam logic [OP_W-1:0] OP_POP     = 2'd2;
  localparam logic [OP_W-1:0] OP_STEAL   = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_STAGED = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the incoming transaction
    logic commit;     // update deque state, write result register
    logic load_read;  // take slot read data into the result register
  } wsdb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_read; // current item takes a job out of the slot memory
  } wsdb_stat_t;

endpackage

// ----- rtl/work_stealing_deque_bank.sv -----
// Top level of the work-stealing deque bank: stream ports, controller and datapath.
//
//  channel | dir | tdata (low bit up)               | tuser         | tlast
//  --------+-----+----------------------------------+---------------+------
//  s_*     | in  | deque_index[2:0], job_id[34:3]   | operation     | -
//  m_*     | out | job_out[31:0]                    | status        | -
//
// Each transaction is captured on acceptance and then executed; a pop or steal that takes
// a job also passes through the registered slot memory read before its result is loaded.
// Execution waits while the result register holds a transaction not yet taken; a new
// input transaction is accepted while a result still waits downstream.
// Reset sets all deque pointers to slot 1 and clears all counts; the slot memory is not
// cleared, and a slot is only ever read after it has been written.
module work_stealing_deque_bank
  import wsdb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // deque_index, job_id, zero pad
  input  logic [OP_W-1:0]     s_tuser,  // operation
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // job_out
  output logic [ST_W-1:0]     m_tuser   // status
);

  wsdb_cmd_t       cmd;
  wsdb_stat_t      stat;
  logic [JOB_W-1:0] res_job;

  wsdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wsdb_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_tuser),
    .in_dq      (s_tdata[DQ_FLD_W-1:0]),
    .in_job     (s_tdata[DQ_FLD_W +: JOB_W]),
    .res_status (m_tuser),
    .res_job    (res_job)
  );

  assign m_tdata = M_DATA_W'(res_job);

endmodule

// ----- rtl/wsdb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wsdb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/wsdb_ctrl.sv -----
// Sequencing state machine and result-valid flag for the deque bank.
module wsdb_ctrl
  import wsdb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  wsdb_stat_t stat,
  output wsdb_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       out_valid_next;

  // result register may be reloaded when empty or emptied this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = stat.needs_read ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        cmd.load_read = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result valid: set on load, cleared when the transaction is taken
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if ((cmd.commit && !stat.needs_read) || cmd.load_read) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/wsdb_dpath.sv -----
// Per-deque pointers, slot memory and result register for the deque bank.
module wsdb_dpath
  import wsdb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  wsdb_cmd_t           cmd,
  output wsdb_stat_t          stat,
  input  logic [OP_W-1:0]     in_op,
  input  logic [DQ_FLD_W-1:0] in_dq,
  input  logic [JOB_W-1:0]    in_job,
  output logic [ST_W-1:0]     res_status,
  output logic [JOB_W-1:0]    res_job
);

  localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(1 % DEQUE_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(DEQUE_DEPTH - 1);
  localparam logic [CNT_W:0]    DEPTH_WIDE = (CNT_W + 1)'(DEQUE_DEPTH);
  localparam logic [ADDR_W-1:0] DEPTH_ADDR = ADDR_W'(DEQUE_DEPTH);

  // slot plus count, reduced once modulo the depth
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0]  n);
    logic [CNT_W:0] sum;
    begin
      sum = (CNT_W + 1)'(s) + (CNT_W + 1)'(n);
      if (sum >= DEPTH_WIDE) begin
        sum = sum - DEPTH_WIDE;
      end
      return SLOT_W'(sum);
    end
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    begin
      return (s == SLOT_LAST) ? '0 : s + 1'b1;
    end
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    begin
      return (s == '0) ? SLOT_LAST : s - 1'b1;
    end
  endfunction

  // captured transaction
  logic [OP_W-1:0]     item_op;
  logic [DQ_FLD_W-1:0] item_dq;
  logic [JOB_W-1:0]    item_job;

  // per-deque state: slot pointers, published and staged counts
  logic [SLOT_W-1:0] top_slot [NUM_DEQUES];
  logic [SLOT_W-1:0] bot_slot [NUM_DEQUES];
  logic [CNT_W-1:0]  held     [NUM_DEQUES];
  logic [CNT_W-1:0]  staged   [NUM_DEQUES];

  logic [DQ_W-1:0]   dq;
  logic              in_bank;
  logic [SLOT_W-1:0] cur_top, cur_bot;
  logic [CNT_W-1:0]  cur_held, cur_staged;
  logic [SLOT_W-1:0] top_next, bot_next;
  logic [CNT_W-1:0]  held_next, staged_next;
  logic [ST_W-1:0]   status_next;
  logic              do_write, do_read;
  logic [SLOT_W-1:0] wr_slot, rd_slot;
  logic [CNT_W:0]    occupancy;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [JOB_W-1:0]  rd_data;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op  <= in_op;
      item_dq  <= in_dq;
      item_job <= in_job;
    end
  end

  assign dq         = DQ_W'(item_dq);
  assign in_bank    = (int'(item_dq) < NUM_DEQUES);
  assign cur_top    = top_slot[dq];
  assign cur_bot    = bot_slot[dq];
  assign cur_held   = held[dq];
  assign cur_staged = staged[dq];
  assign occupancy  = (CNT_W + 1)'(cur_held) + (CNT_W + 1)'(cur_staged);

  // operation decode and pointer update
  always_comb begin
    top_next    = cur_top;
    bot_next    = cur_bot;
    held_next   = cur_held;
    staged_next = cur_staged;
    status_next = ST_DONE;
    do_write    = 1'b0;
    do_read     = 1'b0;
    wr_slot     = slot_add(cur_bot, cur_staged);
    rd_slot     = cur_top;
    if (!in_bank) begin
      status_next = ST_EMPTY;
    end else begin
      unique case (item_op)
        OP_PUSH: begin
          if (occupancy >= DEPTH_WIDE) begin
            status_next = ST_FULL;
          end else begin
            do_write    = 1'b1;
            staged_next = cur_staged + 1'b1;
          end
        end
        OP_PUBLISH: begin
          bot_next    = slot_add(cur_bot, cur_staged);
          held_next   = cur_held + cur_staged;
          staged_next = '0;
        end
        OP_POP: begin
          rd_slot = slot_dec(cur_bot);
          if (cur_staged != '0) begin
            status_next = ST_STAGED;
          end else if (cur_held == '0) begin
            status_next = ST_EMPTY;
          end else begin
            do_read   = 1'b1;
            held_next = cur_held - 1'b1;
            if (cur_held == CNT_W'(1)) begin
              top_next = slot_inc(cur_top);
            end else begin
              bot_next = slot_dec(cur_bot);
            end
          end
        end
        OP_STEAL: begin
          if (cur_held == '0) begin
            status_next = ST_EMPTY;
          end else begin
            do_read   = 1'b1;
            top_next  = slot_inc(cur_top);
            held_next = cur_held - 1'b1;
          end
        end
        default: begin
          status_next = ST_EMPTY;
        end
      endcase
    end
  end

  assign stat.needs_read = do_read;

  // deque state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DEQUES; i++) begin
        top_slot[i] <= SLOT_RESET;
        bot_slot[i] <= SLOT_RESET;
        held[i]     <= '0;
        staged[i]   <= '0;
      end
    end else if (cmd.commit && in_bank) begin
      top_slot[dq] <= top_next;
      bot_slot[dq] <= bot_next;
      held[dq]     <= held_next;
      staged[dq]   <= staged_next;
    end
  end

  // slot memory, one region of DEQUE_DEPTH entries per deque
  assign wr_addr = ADDR_W'(dq) * DEPTH_ADDR + ADDR_W'(wr_slot);
  assign rd_addr = ADDR_W'(dq) * DEPTH_ADDR + ADDR_W'(rd_slot);

  wsdb_ram #(
    .WIDTH (JOB_W),
    .DEPTH (RAM_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.commit && do_write),
    .waddr (wr_addr),
    .wdata (item_job),
    .re    (cmd.commit && do_read),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status <= status_next;
      res_job    <= '0;
    end else if (cmd.load_read) begin
      res_job <= rd_data;
    end
  end

endmodule

// ----- tb/wsdb_checker.sv -----
// Checker for the work-stealing deque bank: predicts each result and compares it.
`timescale 1ns / 1ps

module wsdb_checker
  import wsdb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // deque_index, job_id, zero pad
  input  logic [OP_W-1:0]     s_tuser,   // operation
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,   // job_out
  input  logic [ST_W-1:0]     m_tuser,   // status
  output int                  fail_count,
  output int                  owed,
  output logic [3:0][31:0]    status_hits
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [JOB_W-1:0] job;
  } deque_result_t;

  // Shadow copy of the bank
  logic [31:0]       top_idx [NUM_DEQUES];
  logic [31:0]       bot_idx [NUM_DEQUES];
  logic [CNT_W-1:0]  staged  [NUM_DEQUES];
  logic [JOB_W-1:0]  ring    [RAM_DEPTH];

  deque_result_t     owed_results [$];
  int                bad = 0;
  logic [3:0][31:0]  hits = '0;

  initial begin
    fail_count  = 0;
    owed        = 0;
    status_hits = '0;
  end

  function automatic int unsigned ring_addr(input logic [DQ_FLD_W-1:0] dq,
                                            input logic [31:0] running);
    return dq * DEQUE_DEPTH + int'(running % 32'(DEQUE_DEPTH));
  endfunction

  // Apply one operation to the shadow bank and return what the block should answer
  function automatic deque_result_t apply_deque_op(input logic [OP_W-1:0]     op,
                                                   input logic [DQ_FLD_W-1:0] dq,
                                                   input logic [JOB_W-1:0]    job);
    deque_result_t r;
    logic [31:0]   t;
    logic [31:0]   b;
    logic [31:0]   held;
    r.status = ST_DONE;
    r.job    = '0;
    if (dq >= NUM_DEQUES) begin
      r.status = ST_EMPTY;
      return r;
    end
    t    = top_idx[dq];
    b    = bot_idx[dq];
    held = b - t;
    case (op)
      OP_PUSH: begin
        if (held + 32'(staged[dq]) >= 32'(DEQUE_DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          ring[ring_addr(dq, b + 32'(staged[dq]))] = job;
          staged[dq] = staged[dq] + 1'b1;
        end
      end
      OP_PUBLISH: begin
        bot_idx[dq] = b + 32'(staged[dq]);
        staged[dq]  = '0;
      end
      OP_POP: begin
        if (staged[dq] != 0) begin
          r.status = ST_STAGED;
        end else if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.job = ring[ring_addr(dq, b - 1)];
          // taking the last job moves top rather than bottom
          if (held == 1) top_idx[dq] = t + 1;
          else bot_idx[dq] = b - 1;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.job = ring[ring_addr(dq, t)];
          top_idx[dq] = t + 1;
        end
      end
    endcase
    return r;
  endfunction

  // Outputs are checked before the input of the same edge is predicted, so a
  // stray result can never pair with a transaction accepted at that very edge
  always @(posedge clk) begin : watch
    deque_result_t want;
    if (rst) begin
      for (int d = 0; d < NUM_DEQUES; d++) begin
        top_idx[d] = 32'd1;
        bot_idx[d] = 32'd1;
        staged[d]  = '0;
      end
      owed_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          bad++;
          $display("%0t: result with nothing outstanding: status %0d job_out 0x%08h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = owed_results.pop_front();
          hits[want.status] = hits[want.status] + 1;
          if (m_tuser !== want.status) begin
            bad++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, m_tuser);
          end
          if (m_tdata !== M_DATA_W'(want.job)) begin
            bad++;
            $display("%0t: job_out mismatch: expected 0x%08h, actual 0x%08h",
                     $time, want.job, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        owed_results.push_back(apply_deque_op(s_tuser, s_tdata[DQ_FLD_W-1:0],
                                              s_tdata[DQ_FLD_W +: JOB_W]));
      end
    end
    owed        <= owed_results.size();
    fail_count  <= bad;
    status_hits <= hits;
  end

endmodule

// ----- tb/work_stealing_deque_bank_tb.sv -----
// Testbench top for the work-stealing deque bank: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module work_stealing_deque_bank_tb;
  import wsdb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 450;
  localparam int CALM_TAIL       = 150;
  localparam logic [DQ_FLD_W-1:0] FILL_DQ = 3'd5;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;  // deque_index, job_id, zero pad
  logic [OP_W-1:0]     s_tuser  = '0;  // operation
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // job_out
  logic [ST_W-1:0]     m_tuser;        // status

  int                  fail_count;
  int                  owed;
  logic [3:0][31:0]    status_hits;
  int                  items_sent = 0;
  bit                  jitter_on  = 1'b1;
  bit                  squeeze    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  work_stealing_deque_bank dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  wsdb_checker deque_watch (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .fail_count, .owed, .status_hits
  );

  // Offer one transaction and hold it until accepted; valid stays up unless a gap follows
  task automatic send_op(input logic [OP_W-1:0]     op,
                         input logic [DQ_FLD_W-1:0] dq,
                         input logic [JOB_W-1:0]    job);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= S_DATA_W'({job, dq});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Stop offering until every outstanding result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off when asked
  initial begin : result_sink
    bit squeezed_once;
    squeezed_once = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed_once) begin
        squeezed_once = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int target;
    int k;
    int n;
    logic [DQ_FLD_W-1:0] dq;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty, staged and single-job corners, all ops, field extremes
    send_op(OP_STEAL,   3'd0, 32'h0000_0000);
    send_op(OP_POP,     3'd0, 32'hFFFF_FFFF);
    send_op(OP_PUBLISH, 3'd0, 32'h0000_0000);  // nothing staged
    send_op(OP_PUSH,    3'd0, 32'h0000_0000);
    send_op(OP_POP,     3'd0, 32'h0000_0000);  // refused, job still staged
    send_op(OP_STEAL,   3'd0, 32'h0000_0000);  // staged jobs are not visible
    send_op(OP_PUBLISH, 3'd0, 32'hFFFF_FFFF);
    send_op(OP_PUSH,    3'd0, 32'hFFFF_FFFF);
    send_op(OP_POP,     3'd0, 32'h0000_0000);
    send_op(OP_PUBLISH, 3'd0, 32'h0000_0000);
    send_op(OP_STEAL,   3'd0, 32'h0000_0000);  // oldest
    send_op(OP_POP,     3'd0, 32'h0000_0000);  // last job, top advances
    send_op(OP_POP,     3'd0, 32'h0000_0000);
    send_op(OP_PUSH,    3'd7, 32'hA5A5_A5A5);
    send_op(OP_PUSH,    3'd7, 32'h5A5A_5A5A);
    send_op(OP_PUSH,    3'd7, 32'h1234_5678);
    send_op(OP_PUBLISH, 3'd7, 32'h0000_0000);
    send_op(OP_POP,     3'd7, 32'h0000_0000);
    send_op(OP_STEAL,   3'd7, 32'h0000_0000);
    send_op(OP_POP,     3'd7, 32'h0000_0000);
    send_op(OP_STEAL,   3'd7, 32'h0000_0000);
    send_op(OP_PUSH,    3'd3, 32'h8000_0001);
    send_op(OP_PUBLISH, 3'd3, 32'h0000_0000);
    send_op(OP_STEAL,   3'd3, 32'h0000_0000);
    wait_drained();

    // Fill one deque to capacity while the result side is held off
    squeeze <= 1'b1;
    for (int i = 0; i < DEQUE_DEPTH; i++) send_op(OP_PUSH, FILL_DQ, $urandom);
    squeeze <= 1'b0;
    send_op(OP_PUSH,    FILL_DQ, $urandom);    // full while all staged
    send_op(OP_POP,     FILL_DQ, $urandom);
    send_op(OP_PUBLISH, FILL_DQ, $urandom);
    send_op(OP_PUSH,    FILL_DQ, $urandom);    // full while all published
    repeat (DEQUE_DEPTH + 1)
      send_op($urandom_range(0, 1) ? OP_POP : OP_STEAL, FILL_DQ, $urandom);
    wait_drained();

    // Random: mostly push bursts, publish and takes on one deque; some noise
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (items_sent >= target - CALM_TAIL) jitter_on = 1'b0;
      if ($urandom_range(0, 9) < 7) begin
        dq = DQ_FLD_W'($urandom_range(0, NUM_DEQUES - 1));
        k  = int'($urandom_range(1, 12));
        repeat (k) send_op(OP_PUSH, dq, $urandom);
        // now and then leave jobs staged so that pops get refused
        if ($urandom_range(0, 4) != 0) send_op(OP_PUBLISH, dq, $urandom);
        n = int'($urandom_range(0, k + 2));
        repeat (n) send_op($urandom_range(0, 1) ? OP_POP : OP_STEAL, dq, $urandom);
      end else begin
        send_op(OP_W'($urandom_range(0, 3)), DQ_FLD_W'($urandom_range(0, 7)), $urandom);
      end
    end
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Run covered %0d transactions: %0d done, %0d empty, %0d full, %0d staged refusals",
             items_sent, status_hits[ST_DONE], status_hits[ST_EMPTY],
             status_hits[ST_FULL], status_hits[ST_STAGED]);
    $display("including a full-capacity fill and a %0d-cycle result hold-off",
             HOLD_OFF_CYCLES);
    if (fail_count == 0 && owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", owed);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- work_stealing_deque_bank.f -----
rtl/wsdb_pkg.sv
rtl/wsdb_ram.sv
rtl/wsdb_ctrl.sv
rtl/wsdb_dpath.sv
rtl/work_stealing_deque_bank.sv
tb/wsdb_checker.sv
tb/work_stealing_deque_bank_tb.sv
